/* design/two_tier_cache_placement_top_macros.svh */
// Assertion macros for the two-tier placement block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TWO_TIER_CACHE_PLACEMENT_TOP_MACROS_SVH
`define TWO_TIER_CACHE_PLACEMENT_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TCP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcp assertion failed");

// consequent checked from the next cycle on
`define TCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcp assertion failed");

`endif

/* design/tcp_pkg.sv */
// Shared types and codes for the two-tier placement block.
// No dependencies; used by the top level and the testbench.
package tcp_pkg;

  localparam int FILES    = 256;
  localparam int IDX_W    = 8;
  localparam int SIZE_W   = 40;
  localparam int CNT_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_ACCESS   = 3'd1;
  localparam logic [2:0] OP_MOVE     = 3'd2;
  localparam logic [2:0] OP_SET_OPEN = 3'd3;
  localparam logic [2:0] OP_QUERY    = 3'd4;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [2:0] STAT_PRESENT   = 3'd2;
  localparam logic [2:0] STAT_NO_SPACE  = 3'd3;
  localparam logic [2:0] STAT_IN_TIER   = 3'd4;

  localparam logic [1:0] TIER_FAST    = 2'd0;
  localparam logic [1:0] TIER_SECOND  = 2'd1;
  localparam logic [1:0] TIER_BACKING = 2'd2;
  localparam logic [1:0] TIER_UNKNOWN = 2'd3;

  localparam logic ETIER_FAST   = 1'b0;
  localparam logic ETIER_SECOND = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FAST_CAP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CAP = 1'd1;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [IDX_W-1:0]  file_index;
    logic [SIZE_W-1:0] file_size;
    logic              target_tier;
    logic              open_flag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        tier;
    logic [CNT_W-1:0]  use_count;
    logic [SIZE_W-1:0] fast_used;
    logic [SIZE_W-1:0] second_used;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              tier;
    logic [CNT_W-1:0]  count;
    logic              open;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

/* design/tcp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/two_tier_cache_placement_top.sv */
// Two-tier file placement table: entry RAM, per-entry valid bits and tier byte counters.
// Depends on tcp_pkg, tcp_ram and two_tier_cache_placement_top_macros.svh.
//
// The edge that accepts start reads the entry RAM, and
// busy is then high for one cycle while the entry is updated, written back and the
// tier counters move. The result strobe out_valid is high in the cycle after that, one
// cycle only, and a new command may be accepted in that same cycle; no new command
// is taken while busy is high. The receiver cannot stall the result. The valid bits
// clear at reset; capacity writes are taken at any time the block is idle.
`include "two_tier_cache_placement_top_macros.svh"

module two_tier_cache_placement_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  tcp_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  output tcp_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [tcp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcp_pkg::SIZE_W-1:0]          cfg_wdata
);

  tcp_pkg::state_t state_r, state_nxt;
  logic            accept;
  logic            exec;

  tcp_pkg::in_item_t            req_r;
  logic [tcp_pkg::FILES-1:0]    vld_r;
  logic                         hit_r;
  logic [tcp_pkg::SIZE_W-1:0]   fast_cap_r, second_cap_r;
  logic [tcp_pkg::SIZE_W-1:0]   fast_used_r, fast_used_nxt;
  logic [tcp_pkg::SIZE_W-1:0]   second_used_r, second_used_nxt;
  logic                         out_valid_r;
  tcp_pkg::out_item_t           out_data_r, out_data_nxt;

  tcp_pkg::entry_t              ent_rd;
  tcp_pkg::entry_t              ent_wr;
  logic [tcp_pkg::ENTRY_W-1:0]  ram_rdata;
  logic                         ent_we;
  logic                         set_valid;

  logic [tcp_pkg::SIZE_W-1:0]   op_size;
  logic [tcp_pkg::SIZE_W:0]     fast_sum, second_sum;
  logic                         fast_fit, second_fit;
  logic [tcp_pkg::SIZE_W-1:0]   fast_diff, second_diff;

  logic                         res_missing;
  logic                         res_unknown;

  // ---------------------------------------------------------------- control
  assign accept = start && (state_r == tcp_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcp_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = tcp_pkg::ST_EXEC;
        end
      end
      tcp_pkg::ST_EXEC: begin
        state_nxt = tcp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    unique case (state_r)
      tcp_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      tcp_pkg::ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // ------------------------------------------------------------- entry store
  tcp_ram #(
    .WIDTH (tcp_pkg::ENTRY_W),
    .DEPTH (tcp_pkg::FILES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (req_r.file_index),
    .wdata (ent_wr),
    .re    (accept),
    .raddr (in_data.file_index),
    .rdata (ram_rdata)
  );

  assign ent_rd = tcp_pkg::entry_t'(ram_rdata);

  // share the adders between add (request size) and move (stored size)
  assign op_size    = (req_r.opcode == tcp_pkg::OP_ADD) ? req_r.file_size : ent_rd.size;
  assign fast_sum   = {1'b0, fast_used_r} + {1'b0, op_size};
  assign second_sum = {1'b0, second_used_r} + {1'b0, op_size};
  assign fast_fit   = fast_sum <= {1'b0, fast_cap_r};
  assign second_fit = second_sum <= {1'b0, second_cap_r};
  assign fast_diff   = fast_used_r - ent_rd.size;
  assign second_diff = second_used_r - ent_rd.size;

  // -------------------------------------------------------- modify / result
  always_comb begin
    ent_wr          = ent_rd;
    ent_we          = 1'b0;
    set_valid       = 1'b0;
    fast_used_nxt   = fast_used_r;
    second_used_nxt = second_used_r;
    out_data_nxt.status    = tcp_pkg::STAT_OK;
    out_data_nxt.tier      = tcp_pkg::TIER_UNKNOWN;
    out_data_nxt.use_count = '0;

    case (req_r.opcode) inside
      tcp_pkg::OP_ADD: begin
        if (hit_r) begin
          out_data_nxt.status    = tcp_pkg::STAT_PRESENT;
          out_data_nxt.tier      = {1'b0, ent_rd.tier};
          out_data_nxt.use_count = ent_rd.count;
        end else if (fast_fit || second_fit) begin
          ent_wr.size  = req_r.file_size;
          ent_wr.count = '0;
          ent_wr.open  = 1'b1;
          ent_we       = 1'b1;
          set_valid    = 1'b1;
          if (fast_fit) begin
            ent_wr.tier       = tcp_pkg::ETIER_FAST;
            fast_used_nxt     = fast_sum[tcp_pkg::SIZE_W-1:0];
            out_data_nxt.tier = tcp_pkg::TIER_FAST;
          end else begin
            ent_wr.tier       = tcp_pkg::ETIER_SECOND;
            second_used_nxt   = second_sum[tcp_pkg::SIZE_W-1:0];
            out_data_nxt.tier = tcp_pkg::TIER_SECOND;
          end
        end else begin
          out_data_nxt.status = tcp_pkg::STAT_NO_SPACE;
          out_data_nxt.tier   = tcp_pkg::TIER_BACKING;
        end
      end
      tcp_pkg::OP_ACCESS, tcp_pkg::OP_MOVE, tcp_pkg::OP_SET_OPEN, tcp_pkg::OP_QUERY: begin
        if (!hit_r) begin
          out_data_nxt.status = tcp_pkg::STAT_NOT_FOUND;
        end else begin
          case (req_r.opcode)
            tcp_pkg::OP_ACCESS: begin
              if (ent_rd.count != tcp_pkg::COUNT_MAX) begin
                ent_wr.count = ent_rd.count + tcp_pkg::CNT_W'(1);
              end
              ent_we = 1'b1;
            end
            tcp_pkg::OP_MOVE: begin
              if (ent_rd.tier == req_r.target_tier) begin
                out_data_nxt.status = tcp_pkg::STAT_IN_TIER;
              end else if (req_r.target_tier == tcp_pkg::ETIER_SECOND) begin
                if (second_fit) begin
                  second_used_nxt = second_sum[tcp_pkg::SIZE_W-1:0];
                  fast_used_nxt   = fast_diff;
                  ent_wr.tier     = tcp_pkg::ETIER_SECOND;
                  ent_we          = 1'b1;
                end else begin
                  out_data_nxt.status = tcp_pkg::STAT_NO_SPACE;
                end
              end else begin
                if (fast_fit) begin
                  fast_used_nxt   = fast_sum[tcp_pkg::SIZE_W-1:0];
                  second_used_nxt = second_diff;
                  ent_wr.tier     = tcp_pkg::ETIER_FAST;
                  ent_we          = 1'b1;
                end else begin
                  out_data_nxt.status = tcp_pkg::STAT_NO_SPACE;
                end
              end
            end
            tcp_pkg::OP_SET_OPEN: begin
              ent_wr.open = req_r.open_flag;
              ent_we      = 1'b1;
            end
            default: begin
              ent_we = 1'b0;
            end
          endcase
          out_data_nxt.tier      = {1'b0, ent_wr.tier};
          out_data_nxt.use_count = ent_wr.count;
        end
      end
      default: begin
        // unused opcodes: no change, ok status
        out_data_nxt.status = tcp_pkg::STAT_OK;
      end
    endcase

    out_data_nxt.fast_used   = fast_used_nxt;
    out_data_nxt.second_used = second_used_nxt;

    // hold everything outside the execute cycle
    if (!exec) begin
      ent_we          = 1'b0;
      set_valid       = 1'b0;
      fast_used_nxt   = fast_used_r;
      second_used_nxt = second_used_r;
    end
  end

  // --------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tcp_pkg::ST_IDLE;
      vld_r         <= '0;
      fast_cap_r    <= '0;
      second_cap_r  <= '0;
      fast_used_r   <= '0;
      second_used_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fast_used_r   <= fast_used_nxt;
      second_used_r <= second_used_nxt;
      out_valid_r   <= exec;
      if (set_valid) begin
        vld_r[req_r.file_index] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          tcp_pkg::CFG_FAST_CAP:   fast_cap_r   <= cfg_wdata;
          tcp_pkg::CFG_SECOND_CAP: second_cap_r <= cfg_wdata;
          default: begin
            fast_cap_r <= fast_cap_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
      hit_r <= vld_r[in_data.file_index];
    end
    if (exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // -------------------------------------------------------------- assertions
  assign res_missing = out_valid && (out_data.status == tcp_pkg::STAT_NOT_FOUND);
  assign res_unknown = (out_data.tier == tcp_pkg::TIER_UNKNOWN) && (out_data.use_count == '0);

  `TCP_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `TCP_ASSERT_NEXT(a_result_follows_accept, start && !busy, ##1 out_valid)
  `TCP_ASSERT_NEXT(a_single_exec_cycle, busy, !busy && out_valid)
  `TCP_ASSERT_SAME(a_missing_reports_unknown, res_missing, res_unknown)

endmodule

/* tb/sv/two_tier_cache_placement_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the two-tier file placement table: command driver, result
// monitor and a placement predictor with its own copy of the entry table and counters.
// Depends on tcp_pkg and two_tier_cache_placement_top.
module two_tier_cache_placement_top_tb;
  import tcp_pkg::*;

  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // predictor copy of the block state
  logic              placed_valid [FILES];
  logic [SIZE_W-1:0] placed_size  [FILES];
  logic              placed_tier  [FILES];
  logic [CNT_W-1:0]  placed_count [FILES];
  logic              placed_open  [FILES];
  logic [SIZE_W-1:0] fast_bytes = '0;
  logic [SIZE_W-1:0] second_bytes = '0;
  logic [SIZE_W-1:0] fast_cap = '0;
  logic [SIZE_W-1:0] second_cap = '0;

  in_item_t  cmd_q[$];
  out_item_t placement_q[$];
  logic xfer = 1'b0;
  int gap_pct = 0;
  int mismatches = 0;

  two_tier_cache_placement_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic out_item_t predict_placement(in_item_t c);
    out_item_t r;
    logic [SIZE_W:0] sum;
    logic [IDX_W-1:0] e;
    logic hit;
    e = c.file_index;
    hit = placed_valid[e];
    r.status = STAT_OK;
    r.tier = TIER_UNKNOWN;
    r.use_count = '0;
    if (c.opcode == OP_ADD) begin
      if (hit) begin
        r.status = STAT_PRESENT;
        r.tier = (placed_tier[e] == ETIER_SECOND) ? TIER_SECOND : TIER_FAST;
        r.use_count = placed_count[e];
      end else begin
        sum = fast_bytes + c.file_size;
        if (sum <= fast_cap) begin
          fast_bytes = sum[SIZE_W-1:0];
          r.tier = TIER_FAST;
        end else begin
          sum = second_bytes + c.file_size;
          if (sum <= second_cap) begin
            second_bytes = sum[SIZE_W-1:0];
            r.tier = TIER_SECOND;
          end else begin
            r.status = STAT_NO_SPACE;
            r.tier = TIER_BACKING;
          end
        end
        if (r.status == STAT_OK) begin
          placed_valid[e] = 1'b1;
          placed_size[e] = c.file_size;
          placed_tier[e] = (r.tier == TIER_SECOND) ? ETIER_SECOND : ETIER_FAST;
          placed_count[e] = '0;
          placed_open[e] = 1'b1;
        end
      end
    end else if (c.opcode <= OP_QUERY) begin
      if (!hit) begin
        r.status = STAT_NOT_FOUND;
      end else begin
        case (c.opcode)
          OP_ACCESS: begin
            if (placed_count[e] != COUNT_MAX) placed_count[e] = placed_count[e] + 1'b1;
          end
          OP_MOVE: begin
            if (placed_tier[e] == c.target_tier) begin
              r.status = STAT_IN_TIER;
            end else if (c.target_tier == ETIER_SECOND) begin
              sum = second_bytes + placed_size[e];
              if (sum <= second_cap) begin
                second_bytes = sum[SIZE_W-1:0];
                fast_bytes = fast_bytes - placed_size[e];
                placed_tier[e] = ETIER_SECOND;
              end else begin
                r.status = STAT_NO_SPACE;
              end
            end else begin
              sum = fast_bytes + placed_size[e];
              if (sum <= fast_cap) begin
                fast_bytes = sum[SIZE_W-1:0];
                second_bytes = second_bytes - placed_size[e];
                placed_tier[e] = ETIER_FAST;
              end else begin
                r.status = STAT_NO_SPACE;
              end
            end
          end
          OP_SET_OPEN: placed_open[e] = c.open_flag;
          default: ;
        endcase
        r.tier = (placed_tier[e] == ETIER_SECOND) ? TIER_SECOND : TIER_FAST;
        r.use_count = placed_count[e];
      end
    end
    r.fast_used = fast_bytes;
    r.second_used = second_bytes;
    return r;
  endfunction

  task automatic check_field(string fld, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, fld, want, got);
      mismatches++;
    end
  endtask

  // predict on each accepted command, check each result against the oldest prediction
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      xfer <= 1'b0;
    end else begin
      if (out_valid) begin
        if (placement_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got %0h", $time, out_data);
          mismatches++;
        end else begin
          want = placement_q.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("tier", want.tier, out_data.tier);
          check_field("use_count", want.use_count, out_data.use_count);
          check_field("fast_used", want.fast_used, out_data.fast_used);
          check_field("second_used", want.second_used, out_data.second_used);
        end
      end
      xfer <= start && !busy;
      if (start && !busy) placement_q.push_back(predict_placement(in_data));
    end
  end

  // hold the command until transferred, then advance or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || xfer) begin
      if (cmd_q.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
        start <= 1'b1;
        in_data <= cmd_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic in_item_t make_cmd(logic [2:0] op, logic [IDX_W-1:0] idx,
                                        logic [SIZE_W-1:0] sz, logic tgt, logic opn);
    in_item_t c;
    c.opcode = op;
    c.file_index = idx;
    c.file_size = sz;
    c.target_tier = tgt;
    c.open_flag = opn;
    return c;
  endfunction

  function automatic in_item_t random_cmd(int base);
    in_item_t c;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 25) c.opcode = OP_ADD;
    else if (pick < 45) c.opcode = OP_ACCESS;
    else if (pick < 65) c.opcode = OP_MOVE;
    else if (pick < 78) c.opcode = OP_SET_OPEN;
    else if (pick < 94) c.opcode = OP_QUERY;
    else c.opcode = 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    // keep most commands on a small window so entries get reused
    if ($urandom_range(99, 0) < 85) c.file_index = IDX_W'(base + $urandom_range(31, 0));
    else c.file_index = IDX_W'($urandom());
    pick = $urandom_range(99, 0);
    if (pick < 70) c.file_size = SIZE_W'($urandom_range(1000, 0));
    else if (pick < 90) c.file_size = SIZE_W'($urandom_range(100000, 0));
    else c.file_size = SIZE_W'({$urandom(), $urandom()});
    c.target_tier = 1'($urandom());
    c.open_flag = 1'($urandom());
    return c;
  endfunction

  task automatic drain;
    while (cmd_q.size() != 0 || start || placement_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == CFG_FAST_CAP) fast_cap = val;
    else second_cap = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_random(int n, int base, int gap);
    gap_pct = gap;
    repeat (n) cmd_q.push_back(random_cmd(base));
    drain();
  endtask

  initial begin
    for (int i = 0; i < FILES; i++) begin
      placed_valid[i] = 1'b0;
      placed_size[i] = '0;
      placed_tier[i] = ETIER_FAST;
      placed_count[i] = '0;
      placed_open[i] = 1'b0;
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // zero capacities out of reset: an empty file still fits
    cmd_q.push_back(make_cmd(OP_ADD, 8'd10, '0, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_ADD, 8'd11, 40'd1, 1'b0, 1'b0));
    drain();
    write_capacity(CFG_FAST_CAP, 40'd100);
    write_capacity(CFG_SECOND_CAP, 40'd200);

    cmd_q.push_back(make_cmd(OP_QUERY, 8'd5, '0, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_ACCESS, 8'd5, '0, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_MOVE, 8'd5, '0, 1'b1, 1'b0));
    cmd_q.push_back(make_cmd(OP_SET_OPEN, 8'd5, '0, 1'b0, 1'b1));
    cmd_q.push_back(make_cmd(OP_ADD, 8'd0, 40'd60, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_ADD, 8'd0, 40'd1, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_ADD, 8'd1, 40'd60, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_ADD, 8'd2, 40'd150, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_ADD, 8'd255, 40'd40, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_MOVE, 8'd0, '0, ETIER_FAST, 1'b0));
    cmd_q.push_back(make_cmd(OP_MOVE, 8'd0, '0, ETIER_SECOND, 1'b0));
    cmd_q.push_back(make_cmd(OP_MOVE, 8'd1, '0, ETIER_FAST, 1'b0));
    cmd_q.push_back(make_cmd(OP_MOVE, 8'd255, '0, ETIER_SECOND, 1'b0));
    cmd_q.push_back(make_cmd(OP_MOVE, 8'd0, '0, ETIER_FAST, 1'b0));
    cmd_q.push_back(make_cmd(OP_ACCESS, 8'd0, '0, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_ACCESS, 8'd0, '0, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_SET_OPEN, 8'd0, '0, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_SET_OPEN, 8'd0, '0, 1'b0, 1'b1));
    cmd_q.push_back(make_cmd(OP_QUERY, 8'd0, '0, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(OP_RSVD_LO, 8'd0, SIZE_MAX, 1'b1, 1'b1));
    cmd_q.push_back(make_cmd(3'(OP_RSVD_LO + 1), 8'd255, SIZE_MAX, 1'b1, 1'b1));
    cmd_q.push_back(make_cmd(OP_RSVD_HI, 8'd1, SIZE_MAX, 1'b1, 1'b1));
    cmd_q.push_back(make_cmd(OP_ADD, 8'd3, SIZE_MAX, 1'b1, 1'b1));
    drain();

    write_capacity(CFG_FAST_CAP, 40'd5000);
    write_capacity(CFG_SECOND_CAP, 40'd20000);
    run_random(400, 16, 6);

    // lower both tiers below what is in use: placements must now fail
    write_capacity(CFG_FAST_CAP, '0);
    write_capacity(CFG_SECOND_CAP, '0);
    run_random(300, 48, 64);

    write_capacity(CFG_FAST_CAP, SIZE_MAX);
    write_capacity(CFG_SECOND_CAP, SIZE_MAX);
    run_random(300, 80, 0);

    write_capacity(CFG_FAST_CAP, SIZE_MAX);
    write_capacity(CFG_SECOND_CAP, 40'd3000);
    run_random(250, 112, 0);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
